>>> hw/rtl/pst_pkg.sv
`timescale 1ns / 1ps

package pst_pkg;

  localparam int KEYWORD_BYTES = 9;
  localparam int KW_W          = 8 * KEYWORD_BYTES;
  localparam int KW_IDX_W      = $clog2(KEYWORD_BYTES);
  localparam int NUM_STATES    = 35;
  localparam int NUM_WORDS     = 17;
  localparam int OQ_DEPTH      = 4;
  localparam int OQ_AW         = $clog2(OQ_DEPTH);

  localparam logic [5:0] LENGTH_LIMIT = 6'd63;

  // result class codes
  localparam logic [5:0] CODE_KEYWORD = 6'd21;
  localparam logic [5:0] CODE_INVALID = 6'd43;
  localparam logic [5:0] CODE_END     = 6'd44;
  localparam logic [5:0] NO_FINAL     = 6'd63;

  // scanner states
  localparam logic [5:0] ST_START       = 6'd0;
  localparam logic [5:0] ST_PERIOD      = 6'd1;
  localparam logic [5:0] ST_SEMI        = 6'd2;
  localparam logic [5:0] ST_SLASH       = 6'd3;
  localparam logic [5:0] ST_LPAREN      = 6'd4;
  localparam logic [5:0] ST_EQ          = 6'd5;
  localparam logic [5:0] ST_STAR        = 6'd6;
  localparam logic [5:0] ST_COLON       = 6'd7;
  localparam logic [5:0] ST_ASSIGN      = 6'd8;
  localparam logic [5:0] ST_COLON_END   = 6'd9;
  localparam logic [5:0] ST_COMMA       = 6'd10;
  localparam logic [5:0] ST_PLUS        = 6'd11;
  localparam logic [5:0] ST_MINUS       = 6'd12;
  localparam logic [5:0] ST_GT          = 6'd13;
  localparam logic [5:0] ST_GE          = 6'd14;
  localparam logic [5:0] ST_GT_END      = 6'd15;
  localparam logic [5:0] ST_LT          = 6'd16;
  localparam logic [5:0] ST_LT_END      = 6'd17;
  localparam logic [5:0] ST_LE          = 6'd18;
  localparam logic [5:0] ST_NE          = 6'd19;
  localparam logic [5:0] ST_COMMENT     = 6'd20;
  localparam logic [5:0] ST_COMMENT_END = 6'd21;
  localparam logic [5:0] ST_IDENT       = 6'd22;
  localparam logic [5:0] ST_IDENT_END   = 6'd23;
  localparam logic [5:0] ST_INT         = 6'd24;
  localparam logic [5:0] ST_INT_END     = 6'd25;
  localparam logic [5:0] ST_DOT         = 6'd26;
  localparam logic [5:0] ST_REAL_NOFRAC = 6'd27;
  localparam logic [5:0] ST_FRAC        = 6'd28;
  localparam logic [5:0] ST_REAL_END    = 6'd29;
  localparam logic [5:0] ST_RPAREN      = 6'd30;
  localparam logic [5:0] ST_COMMENT_EOL = 6'd31;
  localparam logic [5:0] ST_BAD_IDENT   = 6'd32;
  localparam logic [5:0] ST_BAD_INT     = 6'd33;
  localparam logic [5:0] ST_BAD_REAL    = 6'd34;

  localparam logic [5:0] FINAL_CODE [NUM_STATES] = '{
    NO_FINAL, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, NO_FINAL, 6'd6, 6'd7, 6'd8, 6'd9,
    6'd10, NO_FINAL, 6'd11, 6'd12, NO_FINAL, 6'd13, 6'd14, 6'd15, NO_FINAL, 6'd16,
    NO_FINAL, 6'd17, NO_FINAL, 6'd18, NO_FINAL, 6'd38, NO_FINAL, 6'd19, 6'd20,
    6'd39, 6'd40, 6'd41, 6'd42
  };

  // finals that leave the current byte for a rescan
  localparam logic [NUM_STATES-1:0] PUSH_MASK =
    (NUM_STATES'(1) << ST_COLON_END) | (NUM_STATES'(1) << ST_GT_END) |
    (NUM_STATES'(1) << ST_LT_END) | (NUM_STATES'(1) << ST_IDENT_END) |
    (NUM_STATES'(1) << ST_INT_END) | (NUM_STATES'(1) << ST_REAL_NOFRAC) |
    (NUM_STATES'(1) << ST_REAL_END) | (NUM_STATES'(1) << ST_COMMENT_EOL);

  // reserved words, right-justified: first character is the highest byte
  localparam logic [KW_W-1:0] KW_TEXT [NUM_WORDS] = '{
    KW_W'("program"), KW_W'("begin"), KW_W'("end"), KW_W'("const"),
    KW_W'("var"), KW_W'("real"), KW_W'("integer"), KW_W'("procedure"),
    KW_W'("else"), KW_W'("read"), KW_W'("write"), KW_W'("while"),
    KW_W'("do"), KW_W'("if"), KW_W'("then"), KW_W'("for"), KW_W'("to")
  };
  localparam int KW_LEN [NUM_WORDS] = '{
    7, 5, 3, 5, 3, 4, 7, 9, 4, 4, 5, 5, 2, 2, 4, 3, 2
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0] token_class;
    logic [5:0] token_length;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] st;
  } nxt_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } kw_t;

  // one processed beat: scanner update and up to two results
  typedef struct packed {
    logic [5:0]          state;
    logic [5:0]          length;
    logic                buf_we;
    logic [KW_IDX_W-1:0] buf_idx;
    logic [7:0]          buf_data;
    logic [1:0]          count;
    out_item_t           res0;
    out_item_t           res1;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return c == " " || c == "\t" || c == "\n";
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    logic r;
    unique case (c)
      ".", ";", "/", "(", ")", "=", "*", ":", ",", "+", "-", ">", "<", "{",
      " ", "\t", "\n": r = 1'b1;
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] sat_inc(input logic [5:0] v);
    return (v >= LENGTH_LIMIT) ? LENGTH_LIMIT : v + 6'd1;
  endfunction

  function automatic nxt_t next_state(input logic [5:0] s, input logic [7:0] c);
    nxt_t r;
    r.ok = 1'b1;
    r.st = ST_START;
    if (c[7]) begin
      r.ok = 1'b0;
    end else begin
      unique case (s)
        ST_START: begin
          if (is_letter(c)) r.st = ST_IDENT;
          else if (is_digit(c)) r.st = ST_INT;
          else begin
            unique case (c)
              ".":     r.st = ST_PERIOD;
              ";":     r.st = ST_SEMI;
              "/":     r.st = ST_SLASH;
              "(":     r.st = ST_LPAREN;
              "=":     r.st = ST_EQ;
              "*":     r.st = ST_STAR;
              ":":     r.st = ST_COLON;
              ",":     r.st = ST_COMMA;
              "+":     r.st = ST_PLUS;
              "-":     r.st = ST_MINUS;
              ">":     r.st = ST_GT;
              "<":     r.st = ST_LT;
              "{":     r.st = ST_COMMENT;
              ")":     r.st = ST_RPAREN;
              default: r.ok = 1'b0;
            endcase
          end
        end
        ST_COLON: r.st = (c == "=") ? ST_ASSIGN : ST_COLON_END;
        ST_GT:    r.st = (c == "=") ? ST_GE : ST_GT_END;
        ST_LT:    r.st = (c == "=") ? ST_LE : ((c == ">") ? ST_NE : ST_LT_END);
        ST_COMMENT: begin
          r.st = (c == "\n") ? ST_COMMENT_EOL : ((c == "}") ? ST_COMMENT_END : ST_COMMENT);
        end
        ST_IDENT: begin
          if (is_letter(c) || is_digit(c)) r.st = ST_IDENT;
          else r.st = is_delim(c) ? ST_IDENT_END : ST_BAD_IDENT;
        end
        ST_INT: begin
          if (is_digit(c)) r.st = ST_INT;
          else if (c == ".") r.st = ST_DOT;
          else r.st = is_delim(c) ? ST_INT_END : ST_BAD_INT;
        end
        ST_DOT: r.st = is_digit(c) ? ST_FRAC : ST_REAL_NOFRAC;
        ST_FRAC: begin
          if (is_digit(c)) r.st = ST_FRAC;
          else r.st = is_delim(c) ? ST_REAL_END : ST_BAD_REAL;
        end
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic kw_t kw_lookup(input logic [KW_W-1:0] kbuf, input logic [5:0] len);
    kw_t  r;
    logic same;
    r.hit  = 1'b0;
    r.code = CODE_KEYWORD;
    for (int w = 0; w < NUM_WORDS; w++) begin
      same = (len == 6'(KW_LEN[w]));
      for (int i = 0; i < KEYWORD_BYTES; i++) begin
        if (i < KW_LEN[w]) begin
          if (kbuf[8*i +: 8] != KW_TEXT[w][8*(KW_LEN[w]-1-i) +: 8]) same = 1'b0;
        end
      end
      if (same && !r.hit) begin
        r.hit  = 1'b1;
        r.code = 6'(CODE_KEYWORD + 6'(w));
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pst_scan_core.sv
`timescale 1ns / 1ps

module pst_scan_core (
  input  logic [5:0]              scan_state,
  input  logic [5:0]              length_count,
  input  logic [pst_pkg::KW_W-1:0] key_buf,
  input  pst_pkg::in_item_t       item,
  output pst_pkg::step_t          step
);
  import pst_pkg::*;

  nxt_t       ns;
  nxt_t       rs;
  kw_t        kw;
  logic [5:0] fin_class;
  logic [5:0] fin_len;
  logic [7:0] c;

  assign c  = item.char_byte;
  assign kw = kw_lookup(key_buf, length_count);
  assign ns = next_state(scan_state, item.end_of_input ? 8'(" ") : c);
  assign rs = next_state(ST_START, c);

  // token closed by the first transition; push-back finals exclude this byte
  always_comb begin
    fin_class = FINAL_CODE[ns.st];
    if (ns.st == ST_IDENT_END && kw.hit) fin_class = kw.code;
    fin_len = PUSH_MASK[ns.st] ? length_count : sat_inc(length_count);
  end

  always_comb begin
    step.state    = scan_state;
    step.length   = length_count;
    step.buf_we   = 1'b0;
    step.buf_idx  = length_count[KW_IDX_W-1:0];
    step.buf_data = c;
    step.count    = 2'd0;
    step.res0     = '{token_class: fin_class, token_length: fin_len, last_of_run: 1'b0};
    step.res1     = '{token_class: CODE_END, token_length: 6'd0, last_of_run: 1'b1};

    if (item.end_of_input) begin
      if (scan_state != ST_START && ns.ok && FINAL_CODE[ns.st] != NO_FINAL) begin
        step.count = 2'd2;
      end else begin
        step.res0  = '{token_class: CODE_END, token_length: 6'd0, last_of_run: 1'b1};
        step.count = 2'd1;
      end
      step.state  = ST_START;
      step.length = 6'd0;
    end else if (!ns.ok) begin
      // whitespace between tokens is dropped silently
      if (!(scan_state == ST_START && is_white(c))) begin
        step.res0  = '{token_class: CODE_INVALID, token_length: sat_inc(length_count),
                       last_of_run: 1'b1};
        step.count = 2'd1;
      end
      step.state  = ST_START;
      step.length = 6'd0;
    end else if (FINAL_CODE[ns.st] != NO_FINAL) begin
      step.res0.last_of_run = 1'b1;
      step.count  = 2'd1;
      step.state  = ST_START;
      step.length = 6'd0;
      if (PUSH_MASK[ns.st]) begin
        // rescan the same byte from the start state
        if (!rs.ok) begin
          if (!is_white(c)) begin
            step.res0.last_of_run = 1'b0;
            step.res1  = '{token_class: CODE_INVALID, token_length: sat_inc(6'd0),
                           last_of_run: 1'b1};
            step.count = 2'd2;
          end
        end else if (FINAL_CODE[rs.st] != NO_FINAL) begin
          step.res0.last_of_run = 1'b0;
          step.res1  = '{token_class: FINAL_CODE[rs.st], token_length: sat_inc(6'd0),
                         last_of_run: 1'b1};
          step.count = 2'd2;
        end else begin
          step.buf_we  = 1'b1;
          step.buf_idx = '0;
          step.state   = rs.st;
          step.length  = sat_inc(6'd0);
        end
      end
    end else begin
      step.buf_we = (length_count < 6'(KEYWORD_BYTES));
      step.length = sat_inc(length_count);
      step.state  = ns.st;
    end
  end

endmodule

>>> hw/rtl/pascal_subset_token_scanner.sv
`timescale 1ns / 1ps

// Token scanner for a small Pascal-like language.
// Input channel (in_valid / in_stall / in_item): one source byte per beat, or an
// end-of-input beat that flushes a pending token and yields the end code.
// Output channel (out_valid / out_stall / out_item): one result per beat with
// class, length and last_of_run, which marks the final result of an input beat.
// An input beat yields zero, one or two results.
// A result passes from the input register through the table lookup into the
// result queue before it reaches the output. Throughput: one input beat per
// cycle while in_stall is low; the output side moves one result per cycle
// while out_stall is low, and a beat with two results writes both into the
// queue. The rate is set by the combinational table lookup between the input
// register and a four-entry result queue.
// in_stall rises when the input register holds a beat and the result queue has
// fewer than two free entries; a stalled receiver therefore backs up the input
// after the queue fills. Nothing is lost or reordered while stalled.
// Reset (rst_n low, synchronous) returns the scanner to its start state with a
// zero token length and empties the input register and the result queue.

module pascal_subset_token_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pst_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pst_pkg::out_item_t  out_item
);
  import pst_pkg::*;

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic [5:0]        state_r;
  logic [5:0]        len_r;
  logic [KW_W-1:0]   kbuf_r;
  out_item_t         oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  wptr_r;
  logic [OQ_AW-1:0]  rptr_r;
  logic [OQ_AW:0]    fill_r;
  logic [OQ_AW:0]    fill_nxt;

  step_t             step;
  logic              space_ok;
  logic              go;
  logic              in_take;
  logic              pop;
  logic [1:0]        push_n;

  pst_scan_core u_core (
    .scan_state   (state_r),
    .length_count (len_r),
    .key_buf      (kbuf_r),
    .item         (s1_item_r),
    .step         (step)
  );

  assign space_ok  = fill_r <= (OQ_AW+1)'(OQ_DEPTH - 2);
  assign go        = s1_valid_r && space_ok;
  assign in_stall  = s1_valid_r && !space_ok;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = fill_r != '0;
  assign out_item  = oq_r[rptr_r];
  assign pop       = out_valid && !out_stall;
  assign push_n    = go ? step.count : 2'd0;
  assign fill_nxt  = fill_r + (OQ_AW+1)'(push_n) - (OQ_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= ST_START;
      len_r      <= 6'd0;
      wptr_r     <= '0;
      rptr_r     <= '0;
      fill_r     <= '0;
    end else begin
      s1_valid_r <= in_take || (s1_valid_r && !go);
      if (go) begin
        state_r <= step.state;
        len_r   <= step.length;
      end
      wptr_r <= wptr_r + OQ_AW'(push_n);
      if (pop) rptr_r <= rptr_r + OQ_AW'(1);
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_item;
    if (go && step.buf_we) kbuf_r[8*step.buf_idx +: 8] <= step.buf_data;
    if (push_n != 2'd0) oq_r[wptr_r] <= step.res0;
    if (push_n == 2'd2) oq_r[wptr_r + OQ_AW'(1)] <= step.res1;
  end

endmodule
